FILE: design/rk4_pkg.sv
// Shared types, constants and helpers for the RK4 oscillator step unit.
// Used by the interfaces, the divider, the arithmetic unit and the top level.
package rk4_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int KW        = WORD_W - 1;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int CFG_IDX_W = 3;
  localparam int D6_SHIFT  = WORD_W + 2;

  // ceil(2^(W+2) / 6): x / 6 == (x * RECIP6) >> (W+2) for any x below 2^W
  localparam logic [WORD_W-1:0] RECIP6 = WORD_W'(((64'd1 << D6_SHIFT) / 6) + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        umag_t;

  localparam word_t WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STEP   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OMEGA   = 3'd0,
    REG_K_REP   = 3'd1,
    REG_K_ATT   = 3'd2,
    REG_DELTA_X = 3'd3,
    REG_SCALING = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WSQ_MUL, S_WSQ_WB, S_DIVR_GO, S_DIVR_WAIT, S_DIVA_GO, S_DIVA_WAIT,
    S_QSEL, S_QM_MUL, S_QM_WB, S_ACCA_DBL, S_ACCA_ADD, S_FI_MUL, S_FI_ADD,
    S_VI_MUL, S_VI_ADD, S_ACCV_DBL, S_ACCV_ADD, S_SF_MUL, S_SF_D6, S_SF_ADD,
    S_SS_MUL, S_SS_D6, S_SS_ADD, S_FIN_MUL, S_FIN_WB, S_DONE
  } state_t;

  typedef struct packed {
    logic  mul_en;
    umag_t mul_a;
    umag_t mul_b;
    logic  mul_neg;
    word_t add_a;
    word_t add_b;
  } alu_req_t;

  typedef struct packed {
    word_t mul_q;
    logic  mul_sat;
    word_t neg_q;
    logic  neg_sat;
    word_t d6;
    word_t add_y;
    logic  add_sat;
  } alu_rsp_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quo;
    logic  sat;
  } div_rsp_t;

  function automatic umag_t mag(input word_t a);
    umag_t u;
    u = umag_t'(a);
    return a[WORD_W-1] ? umag_t'(-u) : u;
  endfunction

endpackage

FILE: design/rk4_if.sv
// Valid/ready channels for input items and result items.
// Depends on rk4_pkg for the word type.
interface rk4_in_if;
  import rk4_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  word_t         load_value;
  word_t         load_slope;
  modport source (output valid, opcode, load_value, load_slope, input ready);
  modport sink   (input valid, opcode, load_value, load_slope, output ready);
endinterface

interface rk4_out_if;
  import rk4_pkg::*;
  logic          valid;
  logic          ready;
  word_t         value_out;
  word_t         slope_out;
  logic          saturated;
  modport source (output valid, value_out, slope_out, saturated, input ready);
  modport sink   (input valid, value_out, slope_out, saturated, output ready);
endinterface

FILE: design/rk4_div.sv
// Radix-2 restoring divider: (num << FRAC_BITS) / den, saturated to the word.
// One quotient bit per cycle. Depends on rk4_pkg.
module rk4_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  rk4_pkg::word_t            num,
  input  logic [rk4_pkg::KW-1:0]    den,
  output rk4_pkg::div_rsp_t         rsp
);
  import rk4_pkg::*;

  logic             active;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [KW-1:0]    dreg;
  logic [KW-1:0]    rem;
  logic [NUM_W-1:0] sh;
  logic [KW:0]      trial;
  logic             ge;
  logic             ovf;

  assign trial = {rem, sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dreg <= den;
        rem  <= '0;
        cnt  <= '0;
        if (den == '0) begin
          // zero stiffness: a nonzero numerator loads all ones, which saturates to the largest word; zero gives zero
          sh   <= (num == '0) ? '0 : '1;
          done <= 1'b1;
        end else begin
          sh     <= {num, {FRAC_BITS{1'b0}}};
          active <= 1'b1;
        end
      end else if (active) begin
        rem <= ge ? KW'(trial - {1'b0, dreg}) : trial[KW-1:0];
        sh  <= {sh[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign ovf      = sh[NUM_W-1:WORD_W-1] != '0;
  assign rsp.busy = active;
  assign rsp.done = done;
  assign rsp.quo  = ovf ? WMAX : word_t'(sh[WORD_W-1:0]);
  assign rsp.sat  = ovf;

endmodule

FILE: design/rk4_alu.sv
// Shared arithmetic unit: registered 32x32 magnitude multiplier with Q-format
// shift/saturate and divide-by-six readouts, plus a saturating adder. Uses rk4_pkg.
module rk4_alu (
  input  logic              clk,
  input  rk4_pkg::alu_req_t req,
  output rk4_pkg::alu_rsp_t rsp
);
  import rk4_pkg::*;

  localparam logic [SH_W-1:0] POS_LIM = SH_W'(WMAX);
  localparam logic [SH_W-1:0] NEG_LIM = SH_W'(1) << (WORD_W - 1);

  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [SH_W-1:0]   shifted;
  word_t             low;
  word_t             d6_mag;
  logic [WORD_W:0]   sum;
  logic              add_ovf;

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
      neg  <= req.mul_neg;
    end
  end

  assign shifted = prod[PROD_W-1:FRAC_BITS];
  assign low     = word_t'(shifted[WORD_W-1:0]);

  always_comb begin
    if (neg) begin
      rsp.mul_sat = shifted > NEG_LIM;
      rsp.mul_q   = rsp.mul_sat ? WMIN : word_t'(-low);
    end else begin
      rsp.mul_sat = shifted > POS_LIM;
      rsp.mul_q   = rsp.mul_sat ? WMAX : low;
    end
  end

  assign rsp.neg_sat = rsp.mul_q == WMIN;
  assign rsp.neg_q   = rsp.neg_sat ? WMAX : word_t'(-rsp.mul_q);

  assign d6_mag = word_t'(prod[D6_SHIFT +: WORD_W-2]);
  assign rsp.d6 = neg ? word_t'(-d6_mag) : d6_mag;

  assign sum     = {req.add_a[WORD_W-1], req.add_a} + {req.add_b[WORD_W-1], req.add_b};
  assign add_ovf = sum[WORD_W] != sum[WORD_W-1];
  assign rsp.add_sat = add_ovf;
  assign rsp.add_y   = add_ovf ? (sum[WORD_W] ? WMIN : WMAX) : word_t'(sum[WORD_W-1:0]);

endmodule

FILE: design/rk4_nonlinear_oscillator_step_unit.sv
// RK4 step unit for f'' = -(omega^2 / k(f')) * f, Q16.16, one item at a time.
// Load and no-op items go straight to the result, a finish scales f by the scaling register, and a step runs
// two serial divisions (omega^2 by each stiffness, done at once when the stiffness is zero)
// plus squaring, stage work and final update on the shared multiplier and adder.
// Input is ready again the cycle after the result transfer. Reset (synchronous, rst high)
// clears f and f' and restores the register defaults. Depends on rk4_pkg, rk4_if, rk4_div, rk4_alu.
module rk4_nonlinear_oscillator_step_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  rk4_pkg::word_t                  cfg_data,
  rk4_in_if.sink                          in_ch,
  rk4_out_if.source                       out_ch
);
  import rk4_pkg::*;

  state_t state, state_next;

  word_t         omega, scaling;
  logic [KW-1:0] k_rep, k_att, delta_x;
  word_t         f, s, wsq, qr, qa, fi, vi, ai, accf, accs, t;
  logic          satr, sata, flag;
  logic [1:0]    st;
  word_t         h, half, c;

  logic          ovalid;
  word_t         oval, oslope;
  logic          osat;

  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic          div_start;
  logic [KW-1:0] div_den;
  div_rsp_t      div_rsp;
  logic          in_xfer;

  assign h       = word_t'({1'b0, delta_x});
  assign half    = h >>> 1;
  assign c       = (st == 2'd2) ? h : half;
  assign in_xfer = in_ch.valid && in_ch.ready;

  rk4_alu u_alu (.clk(clk), .req(alu_req), .rsp(alu_rsp));

  rk4_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(wsq), .den(div_den), .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (opcode_t'(in_ch.opcode) == OP_STEP)        state_next = S_WSQ_MUL;
          else if (opcode_t'(in_ch.opcode) == OP_FINISH) state_next = S_FIN_MUL;
          else                                           state_next = S_DONE;
        end
      end
      S_WSQ_MUL:   state_next = S_WSQ_WB;
      S_WSQ_WB:    state_next = S_DIVR_GO;
      S_DIVR_GO:   state_next = S_DIVR_WAIT;
      S_DIVR_WAIT: if (div_rsp.done) state_next = S_DIVA_GO;
      S_DIVA_GO:   state_next = S_DIVA_WAIT;
      S_DIVA_WAIT: if (div_rsp.done) state_next = S_QSEL;
      S_QSEL:      state_next = S_QM_MUL;
      S_QM_MUL:    state_next = S_QM_WB;
      S_QM_WB:     state_next = S_ACCA_DBL;
      S_ACCA_DBL:  state_next = (st == 2'd0) ? S_FI_MUL : S_ACCA_ADD;
      S_ACCA_ADD:  state_next = (st == 2'd3) ? S_SF_MUL : S_FI_MUL;
      S_FI_MUL:    state_next = S_FI_ADD;
      S_FI_ADD:    state_next = S_VI_MUL;
      S_VI_MUL:    state_next = S_VI_ADD;
      S_VI_ADD:    state_next = S_ACCV_DBL;
      S_ACCV_DBL:  state_next = S_ACCV_ADD;
      S_ACCV_ADD:  state_next = S_QSEL;
      S_SF_MUL:    state_next = S_SF_D6;
      S_SF_D6:     state_next = S_SF_ADD;
      S_SF_ADD:    state_next = S_SS_MUL;
      S_SS_MUL:    state_next = S_SS_D6;
      S_SS_D6:     state_next = S_SS_ADD;
      S_SS_ADD:    state_next = S_DONE;
      S_FIN_MUL:   state_next = S_FIN_WB;
      S_FIN_WB:    state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // operand steering for the shared unit
  always_comb begin
    alu_req       = '0;
    div_start     = 1'b0;
    div_den       = k_att;
    in_ch.ready   = (state == S_IDLE) && !ovalid;
    unique case (state)
      S_WSQ_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(omega);
        alu_req.mul_b   = mag(omega);
      end
      S_DIVR_GO: begin
        div_start = 1'b1;
        div_den   = k_rep;
      end
      S_DIVA_GO: div_start = 1'b1;
      S_QM_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(t);
        alu_req.mul_b   = mag(fi);
        alu_req.mul_neg = t[WORD_W-1] ^ fi[WORD_W-1];
      end
      S_FI_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(c);
        alu_req.mul_b   = mag(vi);
        alu_req.mul_neg = vi[WORD_W-1];
      end
      S_VI_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(c);
        alu_req.mul_b   = mag(ai);
        alu_req.mul_neg = ai[WORD_W-1];
      end
      S_SF_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(accf);
        alu_req.mul_b   = mag(h);
        alu_req.mul_neg = accf[WORD_W-1];
      end
      S_SS_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(accs);
        alu_req.mul_b   = mag(h);
        alu_req.mul_neg = accs[WORD_W-1];
      end
      S_SF_D6, S_SS_D6: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(alu_rsp.mul_q);
        alu_req.mul_b   = RECIP6;
        alu_req.mul_neg = alu_rsp.mul_q[WORD_W-1];
      end
      S_FIN_MUL: begin
        alu_req.mul_en  = 1'b1;
        alu_req.mul_a   = mag(f);
        alu_req.mul_b   = mag(scaling);
        alu_req.mul_neg = f[WORD_W-1] ^ scaling[WORD_W-1];
      end
      S_ACCA_DBL: begin alu_req.add_a = ai;   alu_req.add_b = ai;            end
      S_ACCA_ADD: begin alu_req.add_a = accs; alu_req.add_b = t;             end
      S_FI_ADD:   begin alu_req.add_a = f;    alu_req.add_b = alu_rsp.mul_q; end
      S_VI_ADD:   begin alu_req.add_a = s;    alu_req.add_b = alu_rsp.mul_q; end
      S_ACCV_DBL: begin alu_req.add_a = vi;   alu_req.add_b = vi;            end
      S_ACCV_ADD: begin alu_req.add_a = accf; alu_req.add_b = t;             end
      S_SF_ADD:   begin alu_req.add_a = f;    alu_req.add_b = alu_rsp.d6;    end
      S_SS_ADD:   begin alu_req.add_a = s;    alu_req.add_b = alu_rsp.d6;    end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      omega   <= '0;
      k_rep   <= KW'(65536);
      k_att   <= KW'(65536);
      delta_x <= KW'(655);
      scaling <= word_t'(65536);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OMEGA:   omega   <= cfg_data;
        REG_K_REP:   k_rep   <= cfg_data[KW-1:0];
        REG_K_ATT:   k_att   <= cfg_data[KW-1:0];
        REG_DELTA_X: delta_x <= cfg_data[KW-1:0];
        REG_SCALING: scaling <= cfg_data;
        default: ;
      endcase
    end
  end

  // state, temporaries and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      f      <= '0;
      s      <= '0;
      flag   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            flag <= 1'b0;
            fi   <= f;
            vi   <= s;
            accf <= s;
            st   <= 2'd0;
            if (opcode_t'(in_ch.opcode) == OP_LOAD) begin
              f <= in_ch.load_value;
              s <= in_ch.load_slope;
            end
          end
        end
        S_WSQ_WB: begin
          wsq  <= alu_rsp.mul_q;
          flag <= flag | alu_rsp.mul_sat;
        end
        S_DIVR_WAIT: if (div_rsp.done) begin qr <= div_rsp.quo; satr <= div_rsp.sat; end
        S_DIVA_WAIT: if (div_rsp.done) begin qa <= div_rsp.quo; sata <= div_rsp.sat; end
        S_QSEL: begin
          // stiffness picked by the sign of the stage slope
          t    <= vi[WORD_W-1] ? qr : qa;
          flag <= flag | (vi[WORD_W-1] ? satr : sata);
        end
        S_QM_WB: begin
          ai   <= alu_rsp.neg_q;
          flag <= flag | alu_rsp.mul_sat | alu_rsp.neg_sat;
        end
        S_ACCA_DBL: begin
          if (st == 2'd0) accs <= ai;
          else if (st == 2'd3) t <= ai;
          else begin
            t    <= alu_rsp.add_y;
            flag <= flag | alu_rsp.add_sat;
          end
        end
        S_ACCA_ADD: begin accs <= alu_rsp.add_y; flag <= flag | alu_rsp.add_sat; end
        S_FI_MUL, S_VI_MUL, S_SF_MUL, S_SS_MUL: ;
        S_FI_ADD: begin
          fi   <= alu_rsp.add_y;
          flag <= flag | alu_rsp.mul_sat | alu_rsp.add_sat;
        end
        S_VI_ADD: begin
          vi   <= alu_rsp.add_y;
          flag <= flag | alu_rsp.mul_sat | alu_rsp.add_sat;
          st   <= st + 2'd1;
        end
        S_ACCV_DBL: begin
          if (st == 2'd3) t <= vi;
          else begin
            t    <= alu_rsp.add_y;
            flag <= flag | alu_rsp.add_sat;
          end
        end
        S_ACCV_ADD: begin accf <= alu_rsp.add_y; flag <= flag | alu_rsp.add_sat; end
        S_SF_D6, S_SS_D6: flag <= flag | alu_rsp.mul_sat;
        S_SF_ADD: begin f <= alu_rsp.add_y; flag <= flag | alu_rsp.add_sat; end
        S_SS_ADD: begin s <= alu_rsp.add_y; flag <= flag | alu_rsp.add_sat; end
        S_FIN_WB: begin f <= alu_rsp.mul_q; flag <= flag | alu_rsp.mul_sat; end
        S_DONE: begin
          ovalid <= 1'b1;
          oval   <= f;
          oslope <= s;
          osat   <= flag;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = ovalid;
  assign out_ch.value_out = oval;
  assign out_ch.slope_out = oslope;
  assign out_ch.saturated = osat;

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ch.ready) else $error("input taken twice");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (state == S_IDLE) && !ovalid) else $error("ready while busy");
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_rsp.busy) else $error("divider restarted while busy");
  a_done_posts: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_ch.valid) else $error("result not posted");
`endif

endmodule
